// ===== rtl/bdpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_pkg
// Shared types, sizes and the palette table for the box downscale and
// palette quantizer.
// ----------------------------------------------------------------------------
package bdpq_pkg;

  localparam int MAX_GRID  = 64;
  localparam int MAX_BLOCK = 64;
  localparam int MAX_IMAGE = 4096;

  localparam int IMG_W    = 13;   // image size register width
  localparam int SIZE_W   = 7;    // grid and block size register width
  localparam int POS_W    = 12;   // pixel column and row counters
  localparam int SUB_W    = 6;    // position inside a tile
  localparam int ADDR_W   = 6;    // tile column address of the sum store
  localparam int SUM_W    = 20;
  localparam int AREA_W   = 13;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int PAL_SIZE = 17;
  localparam int PAL_W    = 5;
  localparam int DIST_W   = 18;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_GRID_WIDTH   = 3'd2,
    CFG_GRID_HEIGHT  = 3'd3,
    CFG_BLOCK_WIDTH  = 3'd4,
    CFG_BLOCK_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [6:0] color_id;
    logic       last_cell;
  } cell_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [IMG_W-1:0]  image_width;
    logic [IMG_W-1:0]  image_height;
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
    logic [SIZE_W-1:0] block_width;
    logic [SIZE_W-1:0] block_height;
  } cfg_t;

  // A finished tile on its way from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [5:0]       row;
    logic [5:0]       col;
    logic             last;
  } tile_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MATCH,
    BK_OUT
  } back_state_t;

  // Palette colors in matching order, packed as red, green, blue.
  function automatic logic [23:0] pal_rgb(input logic [PAL_W-1:0] k);
    logic [23:0] c;
    unique case (k)
      5'd0:    c = {8'd255, 8'd255, 8'd255};
      5'd1:    c = {8'd0,   8'd0,   8'd0};
      5'd2:    c = {8'd0,   8'd0,   8'd255};
      5'd3:    c = {8'd0,   8'd128, 8'd0};
      5'd4:    c = {8'd128, 8'd0,   8'd0};
      5'd5:    c = {8'd255, 8'd20,  8'd147};
      5'd6:    c = {8'd139, 8'd69,  8'd19};
      5'd7:    c = {8'd255, 8'd215, 8'd0};
      5'd8:    c = {8'd75,  8'd0,   8'd130};
      5'd9:    c = {8'd220, 8'd220, 8'd220};
      5'd10:   c = {8'd0,   8'd255, 8'd255};
      5'd11:   c = {8'd0,   8'd255, 8'd127};
      5'd12:   c = {8'd255, 8'd0,   8'd0};
      5'd13:   c = {8'd255, 8'd0,   8'd255};
      5'd14:   c = {8'd255, 8'd165, 8'd0};
      5'd15:   c = {8'd255, 8'd250, 8'd205};
      5'd16:   c = {8'd147, 8'd112, 8'd219};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

  // Palette ids in matching order.
  function automatic logic [6:0] pal_code(input logic [PAL_W-1:0] k);
    logic [6:0] id;
    unique case (k)
      5'd0:    id = 7'd0;
      5'd1:    id = 7'd101;
      5'd2:    id = 7'd102;
      5'd3:    id = 7'd103;
      5'd4:    id = 7'd104;
      5'd5:    id = 7'd105;
      5'd6:    id = 7'd106;
      5'd7:    id = 7'd107;
      5'd8:    id = 7'd108;
      5'd9:    id = 7'd1;
      5'd10:   id = 7'd2;
      5'd11:   id = 7'd3;
      5'd12:   id = 7'd4;
      5'd13:   id = 7'd5;
      5'd14:   id = 7'd6;
      5'd15:   id = 7'd7;
      5'd16:   id = 7'd8;
      default: id = 7'd0;
    endcase
    return id;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/box_downscale_palette_quantize.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_downscale_palette_quantize
// Box-filter downscale of an RGB raster stream to a grid of tiles, each
// tile's mean color matched to the nearest entry of a 17-color palette.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the pixel channel (valid/stall); a
//   transfer happens on a clock edge with pixel_valid high and pixel_stall
//   low. One cell result leaves on the cell channel per finished tile.
//   Pixels are taken one per cycle while pixel_stall is low. The tile sums
//   live in a store with one entry per tile column, read at acceptance and
//   written back in the following cycle. A finished tile enters a four-entry
//   queue; the back end loads it, divides (one quotient bit per cycle), scans
//   the palette and shows the result until it is taken, and only then takes
//   the next tile. pixel_stall rises when the queue is nearly full.
//   A configuration write (cfg_valid/cfg_ready, always ready) recomputes the
//   tile position; pixel_stall is high in the cycle of the write and during
//   the recompute.
//   Reset clears positions, sums and the queue and loads a 64x64 image with
//   8x8 tiles in an 8x8 grid. A stalled cell result holds until taken.
// ----------------------------------------------------------------------------
module box_downscale_palette_quantize import bdpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pixel_t            pixel,
  output logic              cell_valid,
  input  logic              cell_stall,
  output cell_t             cell_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [IMG_W-1:0]  cfg_data
);

  logic [IMG_W-1:0]  image_width, image_height;
  logic [SIZE_W-1:0] grid_width, grid_height, block_width, block_height;
  cfg_t              cfg;
  logic              cfg_write;
  logic              push, q_valid, q_pop;
  tile_t             push_data, q_head;
  logic [QCNT_W-1:0] q_level;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd64;
      image_height <= 13'd64;
      grid_width   <= 7'd8;
      grid_height  <= 7'd8;
      block_width  <= 7'd8;
      block_height <= 7'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_GRID_WIDTH:   grid_width   <= cfg_data[SIZE_W-1:0];
        CFG_GRID_HEIGHT:  grid_height  <= cfg_data[SIZE_W-1:0];
        CFG_BLOCK_WIDTH:  block_width  <= cfg_data[SIZE_W-1:0];
        CFG_BLOCK_HEIGHT: block_height <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one; oversize values clamp to the maximum.
  always_comb begin
    cfg.image_width  = (image_width == '0) ? 13'd1 :
                       (image_width > 13'(MAX_IMAGE)) ? 13'(MAX_IMAGE) : image_width;
    cfg.image_height = (image_height == '0) ? 13'd1 :
                       (image_height > 13'(MAX_IMAGE)) ? 13'(MAX_IMAGE) : image_height;
    cfg.grid_width   = (grid_width == '0) ? 7'd1 :
                       (grid_width > 7'(MAX_GRID)) ? 7'(MAX_GRID) : grid_width;
    cfg.grid_height  = (grid_height == '0) ? 7'd1 :
                       (grid_height > 7'(MAX_GRID)) ? 7'(MAX_GRID) : grid_height;
    cfg.block_width  = (block_width == '0) ? 7'd1 :
                       (block_width > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : block_width;
    cfg.block_height = (block_height == '0) ? 7'd1 :
                       (block_height > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : block_height;
  end

  bdpq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_write   (cfg_write),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_level     (q_level),
    .push        (push),
    .push_data   (push_data)
  );

  bdpq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head),
    .level     (q_level)
  );

  bdpq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data)
  );

endmodule
`default_nettype wire

// ===== rtl/bdpq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_front
// Takes pixels, tracks raster and tile position, accumulates tile sums in a
// per-column store and hands finished tiles to the queue.
// ----------------------------------------------------------------------------
module bdpq_front import bdpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              cfg_write,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pixel_t            pixel,
  input  logic [QCNT_W-1:0] q_level,
  output logic              push,
  output tile_t             push_data
);

  // Raster and tile position.
  logic [POS_W-1:0] col, row, tc, tr;
  logic [SUB_W-1:0] cx, ry;

  // Position recompute after a configuration write.
  logic             sync_busy;
  logic [3:0]       sync_cnt;
  logic [POS_W-1:0] num_c, num_r, quot_c, quot_r;
  logic [SUB_W-1:0] rem_c, rem_r;
  logic [SUB_W:0]   rs_c, rs_r;
  logic             ge_c, ge_r;
  logic [SUB_W:0]   rn_c, rn_r;

  // Sum store and its second stage.
  logic [3*SUM_W-1:0] sums_mem [MAX_GRID];
  logic [MAX_GRID-1:0] vbits;
  logic [3*SUM_W-1:0] rd_data, fwd_data, b_base, b_sum, b_wdata;
  logic               rd_vld, fwd_hit;
  logic               b_valid, b_finish, b_last;
  logic [ADDR_W-1:0]  b_addr;
  logic [5:0]         b_row;
  pixel_t             b_pix;

  logic accept, col_wrap, row_wrap, cx_last, ry_last, in_grid, finish, last;
  logic [ADDR_W-1:0] addr;

  // A configuration write takes its edge alone, so no pixel is taken with it.
  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = cfg_write || sync_busy || (q_level >= QCNT_W'(QDEPTH - 1));
  assign addr        = tc[ADDR_W-1:0];

  // Position decode for the current pixel.
  always_comb begin
    col_wrap = ({1'b0, col} + 13'd1) >= cfg.image_width;
    row_wrap = ({1'b0, row} + 13'd1) >= cfg.image_height;
    cx_last  = ({1'b0, cx} + 7'd1) == cfg.block_width;
    ry_last  = ({1'b0, ry} + 7'd1) == cfg.block_height;
    in_grid  = (tc < {5'd0, cfg.grid_width}) && (tr < {5'd0, cfg.grid_height});
    finish   = in_grid && cx_last && ry_last;
    last     = (tc == {5'd0, cfg.grid_width - 7'd1}) &&
               (tr == {5'd0, cfg.grid_height - 7'd1});
  end

  // One restoring division step for column and row over the block size.
  always_comb begin
    rs_c = {rem_c, num_c[POS_W-1]};
    rs_r = {rem_r, num_r[POS_W-1]};
    ge_c = rs_c >= cfg.block_width;
    ge_r = rs_r >= cfg.block_height;
    rn_c = ge_c ? rs_c - cfg.block_width : rs_c;
    rn_r = ge_r ? rs_r - cfg.block_height : rs_r;
  end

  // Position counters and recompute sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      tc        <= '0;
      tr        <= '0;
      cx        <= '0;
      ry        <= '0;
      sync_busy <= 1'b0;
      sync_cnt  <= '0;
    end else if (cfg_write) begin
      sync_busy <= 1'b1;
      sync_cnt  <= '0;
      num_c     <= col;
      num_r     <= row;
      rem_c     <= '0;
      rem_r     <= '0;
      quot_c    <= '0;
      quot_r    <= '0;
    end else if (sync_busy) begin
      num_c  <= {num_c[POS_W-2:0], 1'b0};
      num_r  <= {num_r[POS_W-2:0], 1'b0};
      rem_c  <= rn_c[SUB_W-1:0];
      rem_r  <= rn_r[SUB_W-1:0];
      quot_c <= {quot_c[POS_W-2:0], ge_c};
      quot_r <= {quot_r[POS_W-2:0], ge_r};
      sync_cnt <= sync_cnt + 4'd1;
      if (sync_cnt == 4'(POS_W - 1)) begin
        sync_busy <= 1'b0;
        cx <= rn_c[SUB_W-1:0];
        ry <= rn_r[SUB_W-1:0];
        tc <= {quot_c[POS_W-2:0], ge_c};
        tr <= {quot_r[POS_W-2:0], ge_r};
      end
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        cx  <= '0;
        tc  <= '0;
        if (row_wrap) begin
          row <= '0;
          ry  <= '0;
          tr  <= '0;
        end else begin
          row <= row + 12'd1;
          if (ry_last) begin
            ry <= '0;
            tr <= tr + 12'd1;
          end else begin
            ry <= ry + 6'd1;
          end
        end
      end else begin
        col <= col + 12'd1;
        if (cx_last) begin
          cx <= '0;
          tc <= tc + 12'd1;
        end else begin
          cx <= cx + 6'd1;
        end
      end
    end
  end

  // Sum store: read at acceptance, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (b_valid) begin
      sums_mem[b_addr] <= b_wdata;
    end
    if (accept) begin
      rd_data <= sums_mem[addr];
    end
  end

  // Second stage control, entry valid bits and same-edge forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits   <= '0;
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (b_valid) begin
        vbits[b_addr] <= 1'b1;
      end
      b_valid <= accept && in_grid;
      fwd_hit <= b_valid && (b_addr == addr);
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_vld   <= vbits[addr];
      fwd_data <= b_wdata;
      b_pix    <= pixel;
      b_addr   <= addr;
      b_row    <= tr[5:0];
      b_finish <= finish;
      b_last   <= last;
    end
  end

  // Add the pixel to its tile sums; a finished tile restarts at zero.
  always_comb begin
    b_base = fwd_hit ? fwd_data : (rd_vld ? rd_data : '0);
    b_sum  = {b_base[3*SUM_W-1:2*SUM_W] + {12'd0, b_pix.red},
              b_base[2*SUM_W-1:SUM_W]   + {12'd0, b_pix.green},
              b_base[SUM_W-1:0]         + {12'd0, b_pix.blue}};
    b_wdata = b_finish ? '0 : b_sum;
    push    = b_valid && b_finish;
    push_data.red_sum   = b_sum[3*SUM_W-1:2*SUM_W];
    push_data.green_sum = b_sum[2*SUM_W-1:SUM_W];
    push_data.blue_sum  = b_sum[SUM_W-1:0];
    push_data.row       = b_row;
    push_data.col       = b_addr;
    push_data.last      = b_last;
  end

endmodule
`default_nettype wire

// ===== rtl/bdpq_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_queue
// Short queue of finished tiles between the front and the back.
// ----------------------------------------------------------------------------
module bdpq_queue import bdpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tile_t             push_data,
  input  logic              pop,
  output logic              not_empty,
  output tile_t             head,
  output logic [QCNT_W-1:0] level
);

  tile_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign not_empty = level != '0;
  assign head      = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdpq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_back
// Divides a tile's sums by its area, matches the mean to the palette one
// entry per cycle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bdpq_back import bdpq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  tile_t q_head,
  output logic  q_pop,
  output logic  cell_valid,
  input  logic  cell_stall,
  output cell_t cell_data
);

  back_state_t state, state_next;

  logic [4:0]        cnt;
  logic [PAL_W-1:0]  k;
  logic [AREA_W-1:0] area;
  logic [SUM_W-1:0]  num [3];
  logic [SUM_W-1:0]  quot [3];
  logic [11:0]       rem [3];
  logic [AREA_W-1:0] rs [3];
  logic [AREA_W-1:0] rn [3];
  logic [2:0]        ge;
  logic [SUM_W-1:0]  qf [3];
  logic [7:0]        mean [3];
  logic [7:0]        meanq [3];
  logic [23:0]       pc;
  logic signed [8:0] diff [3];
  logic [17:0]       sq [3];
  logic [DIST_W-1:0] sq_total, best;
  logic [6:0]        best_id;
  logic [5:0]        o_row, o_col;
  logic              o_last;
  logic              div_done, match_done, take;

  assign div_done   = cnt == 5'(SUM_W - 1);
  assign match_done = k == PAL_W'(PAL_SIZE - 1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid) state_next = BK_DIV;
      BK_DIV:   if (div_done) state_next = BK_MATCH;
      BK_MATCH: if (match_done) state_next = BK_OUT;
      BK_OUT:   if (!cell_stall) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop      = (state == BK_IDLE) && q_valid;
    cell_valid = state == BK_OUT;
  end

  assign take = q_pop;

  // Three restoring division steps in parallel, one quotient bit a cycle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = {rem[i], num[i][SUM_W-1]};
      ge[i] = rs[i] >= area;
      rn[i] = ge[i] ? rs[i] - area : rs[i];
      qf[i] = {quot[i][SUM_W-2:0], ge[i]};
      mean[i] = (qf[i][SUM_W-1:8] != '0) ? 8'hFF : qf[i][7:0];
    end
  end

  // Squared distance to palette entry k.
  always_comb begin
    pc = pal_rgb(k);
    diff[0] = $signed({1'b0, meanq[0]}) - $signed({1'b0, pc[23:16]});
    diff[1] = $signed({1'b0, meanq[1]}) - $signed({1'b0, pc[15:8]});
    diff[2] = $signed({1'b0, meanq[2]}) - $signed({1'b0, pc[7:0]});
    for (int i = 0; i < 3; i++) begin
      sq[i] = 18'(diff[i] * diff[i]);
    end
    sq_total = sq[0] + sq[1] + sq[2];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          num[0] <= q_head.red_sum;
          num[1] <= q_head.green_sum;
          num[2] <= q_head.blue_sum;
          for (int i = 0; i < 3; i++) begin
            rem[i]  <= '0;
            quot[i] <= '0;
          end
          area   <= AREA_W'(cfg.block_width * cfg.block_height);
          o_row  <= q_head.row;
          o_col  <= q_head.col;
          o_last <= q_head.last;
          cnt    <= '0;
        end
      end
      BK_DIV: begin
        for (int i = 0; i < 3; i++) begin
          num[i]  <= {num[i][SUM_W-2:0], 1'b0};
          rem[i]  <= rn[i][11:0];
          quot[i] <= qf[i];
          meanq[i] <= mean[i];
        end
        cnt <= cnt + 5'd1;
        k   <= '0;
      end
      BK_MATCH: begin
        if (k == '0 || sq_total < best) begin
          best    <= sq_total;
          best_id <= pal_code(k);
        end
        k <= k + PAL_W'(1);
      end
      BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign cell_data.cell_row  = o_row;
  assign cell_data.cell_col  = o_col;
  assign cell_data.color_id  = best_id;
  assign cell_data.last_cell = o_last;

endmodule
`default_nettype wire

// ===== rtl/bdpq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdpq_port_checks
// Port-level checks for the box downscale and palette quantizer.
// ----------------------------------------------------------------------------
module bdpq_port_checks import bdpq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              pixel_valid,
  input logic              pixel_stall,
  input pixel_t            pixel,
  input logic              cell_valid,
  input logic              cell_stall,
  input cell_t             cell_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [2:0]        cfg_index,
  input logic [IMG_W-1:0]  cfg_data
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_stall |=> cell_valid && $stable(cell_data))
    else $error("stalled cell result changed");

  // No result right after reset.
  assert property (@(posedge clk) rst |=> !cell_valid)
    else $error("cell result valid after reset");

  // Only palette ids appear.
  assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> (cell_data.color_id <= 7'd8) ||
                   (cell_data.color_id >= 7'd101 && cell_data.color_id <= 7'd108))
    else $error("color id outside the palette");

  // Pixel intake pauses while the position is recomputed after a write.
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> pixel_stall)
    else $error("pixel taken during position recompute");

endmodule

bind box_downscale_palette_quantize bdpq_port_checks u_bdpq_port_checks (.*);
`default_nettype wire
